// ----- hw/rtl/sswe_pkg.sv -----
// Shared constants, types and fixed-point helpers for the stereo shelf EQ.
// No dependencies; every other file of the block imports this package.
package sswe_pkg;

  localparam int SAMPLE_W = 24;
  localparam int ST_W     = 32;
  localparam int FRAC     = ST_W - SAMPLE_W;
  localparam int CF_W     = 16;
  localparam int PROD_W   = ST_W + CF_W + 1;
  localparam int ACC_W    = PROD_W + 1;
  localparam int CFG_W    = 17;
  localparam int GAIN_W   = 14;
  localparam int IDX_W    = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_BASS_POLE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_TREBLE_POLE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MID_FEED     = 3'd2;
  localparam logic [IDX_W-1:0] REG_MID_BACK     = 3'd3;
  localparam logic [IDX_W-1:0] REG_BASS_BLEND   = 3'd4;
  localparam logic [IDX_W-1:0] REG_TREBLE_BLEND = 3'd5;
  localparam logic [IDX_W-1:0] REG_OUT_GAIN     = 3'd6;
  localparam logic [IDX_W-1:0] REG_WIDTH_SOLO   = 3'd7;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = 14'd4096;
  localparam logic [CFG_W-1:0]  WIDTH_RESET = 17'd16384;

  typedef logic signed [ST_W-1:0]   st_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [3:0] {
    LS_BASS_MUL,
    LS_BASS_UPD,
    LS_SPLIT,
    LS_FEED,
    LS_TREB_MUL,
    LS_TREB_UPD,
    LS_BACK,
    LS_TREB_BLEND,
    LS_TREB_OUT,
    LS_SUM
  } lane_step_t;

  typedef struct packed {
    logic [CF_W-1:0] bass_pole;
    logic [CF_W-1:0] treble_pole;
    logic [CF_W-1:0] mid_feed;
    logic [CF_W-1:0] mid_back;
    logic [CF_W-1:0] bass_blend;
    logic [CF_W-1:0] treble_blend;
    logic            solo;
  } lane_coef_t;

  typedef struct packed {
    logic       load;
    logic       run;
    lane_step_t step;
  } lane_ctl_t;

  function automatic acc_t ext(input st_t v);
    return ACC_W'(v);
  endfunction

  // signed state times unsigned coefficient, exact
  function automatic prod_t mul_c(input st_t v, input logic [CF_W-1:0] c);
    prod_t a;
    prod_t b;
    a = PROD_W'(v);
    b = prod_t'({{(PROD_W-CF_W){1'b0}}, c});
    return a * b;
  endfunction

  // floor division by a power of two
  function automatic acc_t trunc_sh(input prod_t p, input int unsigned s);
    return ACC_W'(p >>> s);
  endfunction

  function automatic acc_t trunc_acc(input acc_t v, input int unsigned s);
    return v >>> s;
  endfunction

  function automatic st_t sat_st(input acc_t v);
    acc_t hi;
    acc_t lo;
    hi = {{(ACC_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[ST_W-1:0];
    if (v < lo) return lo[ST_W-1:0];
    return v[ST_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_smp(input acc_t v);
    acc_t hi;
    acc_t lo;
    hi = {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[SAMPLE_W-1:0];
    if (v < lo) return lo[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/sswe_if.sv -----
// Stream interfaces for sample pairs into and out of the stereo shelf EQ.
// Depends on sswe_pkg for the sample width.
interface sswe_in_if import sswe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;
  logic                       block_last;

  modport source (output valid, left_in, right_in, block_last, input ready);
  modport sink   (input valid, left_in, right_in, block_last, output ready);
endinterface

interface sswe_out_if import sswe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       block_end;

  modport source (output valid, left_out, right_out, block_end, input ready);
  modport sink   (input valid, left_out, right_out, block_end, output ready);
endinterface

// ----- hw/rtl/sswe_lane.sv -----
// One channel lane: bass shelf, mid section and high shelf with band sum.
// Depends on sswe_pkg; stepped by the sequencer in the top level.
module sswe_lane import sswe_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  lane_ctl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  lane_coef_t                 coef,
  output st_t                        wet
);

  st_t   x, e, b, mi, dd, eh, bo, mo, h, d, hd, ho;
  prod_t pa, pb, pc, pd, pe, pf;

  // filter memories
  always_ff @(posedge clk) begin
    if (rst) begin
      b <= '0;
      h <= '0;
      d <= '0;
    end else if (ctl.run) begin
      case (ctl.step)
        LS_BASS_UPD: b <= sat_st(ext(b) + trunc_sh(pa, 15));
        LS_TREB_UPD: h <= sat_st(ext(h) + trunc_sh(pd, 15));
        LS_BACK:     d <= sat_st(ext(mi) - trunc_sh(pe, 15));
        default: ;
      endcase
    end
  end

  // working values
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= {sample, {FRAC{1'b0}}};
      e <= sat_st(ext(st_t'({sample, {FRAC{1'b0}}})) - ext(b));
    end else if (ctl.run) begin
      case (ctl.step)
        LS_BASS_MUL: pa <= mul_c(e, coef.bass_pole);
        LS_SPLIT: begin
          mi <= sat_st(ext(x) - ext(b));
          dd <= sat_st(ext(b) - ext(x));
        end
        LS_FEED: begin
          pb <= mul_c(dd, coef.bass_blend);
          pc <= mul_c(mi, coef.mid_feed);
          eh <= sat_st(ext(mi) - ext(h));
        end
        LS_TREB_MUL: begin
          pd <= mul_c(eh, coef.treble_pole);
          bo <= sat_st(ext(x) + trunc_sh(pb, 14));
          mo <= sat_st(trunc_sh(pc, 14) + ext(d));
        end
        LS_TREB_UPD:   pe <= mul_c(mo, coef.mid_back);
        LS_BACK:       hd <= sat_st(ext(h) - ext(mi));
        LS_TREB_BLEND: pf <= mul_c(hd, coef.treble_blend);
        LS_TREB_OUT:   ho <= sat_st(ext(mi) + trunc_sh(pf, 14));
        LS_SUM:        wet <= coef.solo ? mo : sat_st(ext(bo) + ext(mo) + ext(ho));
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sswe_mix.sv -----
// Merge stage: mid/side split, width scaling, output gain and saturation.
// Depends on sswe_pkg and the sswe_out_if interface.
module sswe_mix import sswe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  st_t               wet_l,
  input  st_t               wet_r,
  input  logic              last,
  input  logic [CF_W-1:0]   scale,
  input  logic [GAIN_W-1:0] gain,
  output logic              idle,
  sswe_out_if.source        out_ch
);

  typedef enum logic [2:0] {
    MX_IDLE,
    MX_SCALE,
    MX_SIDE,
    MX_SUM,
    MX_GAIN,
    MX_OUT
  } mix_state_t;

  mix_state_t state;
  st_t        m, sh, sd, a, q;
  prod_t      ps, pl, pr;
  logic       last_q;
  logic       emit;

  assign idle = (state == MX_IDLE);
  // load the output register when it is free or being emptied this cycle
  assign emit = (state == MX_OUT) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= MX_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      if (emit) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        MX_IDLE: begin
          if (start) begin
            m      <= sat_st(trunc_acc(ext(wet_l) + ext(wet_r), 1));
            sh     <= sat_st(trunc_acc(ext(wet_l) - ext(wet_r), 1));
            last_q <= last;
            state  <= MX_SCALE;
          end
        end
        MX_SCALE: begin
          ps    <= mul_c(sh, scale);
          state <= MX_SIDE;
        end
        MX_SIDE: begin
          sd    <= sat_st(trunc_sh(ps, 14));
          state <= MX_SUM;
        end
        MX_SUM: begin
          a     <= sat_st(ext(m) + ext(sd));
          q     <= sat_st(ext(m) - ext(sd));
          state <= MX_GAIN;
        end
        MX_GAIN: begin
          pl    <= mul_c(a, CF_W'(gain));
          pr    <= mul_c(q, CF_W'(gain));
          state <= MX_OUT;
        end
        MX_OUT: begin
          // hold here until the output register is free
          if (emit) begin
            out_ch.left_out  <= sat_smp(trunc_sh(pl, 12 + FRAC));
            out_ch.right_out <= sat_smp(trunc_sh(pr, 12 + FRAC));
            out_ch.block_end <= last_q;
            state            <= MX_IDLE;
          end
        end
        default: state <= MX_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/stereo_shelf_eq_width_enhancer_top.sv -----
// Top level of the stereo shelf EQ with width control: register file,
// lane sequencer, two channel lanes and the merge stage. Uses sswe_pkg.
//
// Each accepted word is one stereo pair. Both channel lanes run the same
// ten-step sequence side by side (bass low-pass update, low-cut split, mid
// section, high-shelf update, blend and band sum), one registered multiply
// or saturating add per step, and the input takes no new word until the
// lanes have finished the pair and handed it on to the merge stage. The
// chain of dependent multiplies inside one channel lane sets that pace.
// The merge stage then steps through the mid/side split on the handoff
// cycle, width scale, side truncation, sum and difference, output gain
// and the output register before a word is offered; it runs while the
// lanes already work on the next pair, and its output register holds a
// finished word while the lanes go on. Registers are written through
// cfg_we/cfg_index/cfg_data and take effect for pairs that start after
// the write; write them only while no pair is in flight.
// Unused index codes do not exist: the index is three bits for eight
// registers. Reset clears the filter memories and loads the register
// defaults (unity output gain, unity width, solo off).
module stereo_shelf_eq_width_enhancer_top import sswe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  sswe_in_if.sink          in_ch,
  sswe_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // configuration registers
  lane_coef_t        coef;
  logic [GAIN_W-1:0] out_gain;
  logic [CF_W-1:0]   width_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.bass_pole    <= '0;
      coef.treble_pole  <= '0;
      coef.mid_feed     <= '0;
      coef.mid_back     <= '0;
      coef.bass_blend   <= '0;
      coef.treble_blend <= '0;
      coef.solo         <= WIDTH_RESET[CF_W];
      out_gain          <= GAIN_RESET;
      width_scale       <= WIDTH_RESET[CF_W-1:0];
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASS_POLE:    coef.bass_pole    <= cfg_data[CF_W-1:0];
        REG_TREBLE_POLE:  coef.treble_pole  <= cfg_data[CF_W-1:0];
        REG_MID_FEED:     coef.mid_feed     <= cfg_data[CF_W-1:0];
        REG_MID_BACK:     coef.mid_back     <= cfg_data[CF_W-1:0];
        REG_BASS_BLEND:   coef.bass_blend   <= cfg_data[CF_W-1:0];
        REG_TREBLE_BLEND: coef.treble_blend <= cfg_data[CF_W-1:0];
        REG_OUT_GAIN:     out_gain          <= cfg_data[GAIN_W-1:0];
        REG_WIDTH_SOLO: begin
          width_scale <= cfg_data[CF_W-1:0];
          coef.solo   <= cfg_data[CF_W];
        end
        default: ;
      endcase
    end
  end

  // lane sequencer: busy while stepping, done while the lane results
  // wait for the merge stage to take them
  lane_step_t step;
  logic       busy;
  logic       done;
  logic       mix_idle;
  logic       mix_start;
  logic       accept;
  logic       last_q;
  lane_ctl_t  ctl;
  st_t        wet_l;
  st_t        wet_r;

  assign mix_start   = done && mix_idle;
  assign in_ch.ready = !busy && (!done || mix_start);
  assign accept      = in_ch.valid && in_ch.ready;

  assign ctl = '{load: accept, run: busy, step: step};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= LS_BASS_MUL;
    end else begin
      if (mix_start) done <= 1'b0;
      if (accept) begin
        busy   <= 1'b1;
        step   <= LS_BASS_MUL;
        last_q <= in_ch.block_last;
      end else if (busy) begin
        if (step == LS_SUM) begin
          // lanes finished: hand the pair to the merge stage
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= lane_step_t'(step + 4'd1);
        end
      end
    end
  end

  sswe_lane u_lane_l (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (in_ch.left_in),
    .coef   (coef),
    .wet    (wet_l)
  );

  sswe_lane u_lane_r (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (in_ch.right_in),
    .coef   (coef),
    .wet    (wet_r)
  );

  sswe_mix u_mix (
    .clk    (clk),
    .rst    (rst),
    .start  (mix_start),
    .wet_l  (wet_l),
    .wet_r  (wet_r),
    .last   (last_q),
    .scale  (width_scale),
    .gain   (out_gain),
    .idle   (mix_idle),
    .out_ch (out_ch)
  );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for stereo_shelf_eq_width_enhancer_top: random and directed stereo pairs,
// a bit-exact shelf EQ / width predictor and an in-order result check. Needs sswe_pkg, sswe_if.
module tb import sswe_pkg::*;;

  typedef logic signed [SAMPLE_W-1:0] smp_t;
  typedef logic [CFG_W-1:0] reg_plan_t [8];

  typedef struct packed {
    smp_t left;
    smp_t right;
    logic last;
  } pair_t;

  // Tracks register contents and filter memories, and queues the pairs the block must return.
  class stereo_eq_ledger;
    logic [15:0] bass_pole, treble_pole, mid_feed, mid_back, bass_blend, treble_blend;
    logic [15:0] side_scale;
    logic [13:0] out_gain;
    bit          solo;
    longint      bass_mem[2], mid_mem[2], treble_mem[2];
    pair_t       due_pairs[$];
    int          errors;

    function new();
      bass_pole = 0; treble_pole = 0; mid_feed = 0; mid_back = 0;
      bass_blend = 0; treble_blend = 0;
      out_gain = GAIN_RESET;
      side_scale = WIDTH_RESET[15:0];
      solo = WIDTH_RESET[16];
      foreach (bass_mem[c]) begin
        bass_mem[c] = 0; mid_mem[c] = 0; treble_mem[c] = 0;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_BASS_POLE:    bass_pole = data[15:0];
        REG_TREBLE_POLE:  treble_pole = data[15:0];
        REG_MID_FEED:     mid_feed = data[15:0];
        REG_MID_BACK:     mid_back = data[15:0];
        REG_BASS_BLEND:   bass_blend = data[15:0];
        REG_TREBLE_BLEND: treble_blend = data[15:0];
        REG_OUT_GAIN:     out_gain = data[13:0];
        REG_WIDTH_SOLO: begin
          side_scale = data[15:0];
          solo = data[16];
        end
        default: ;
      endcase
    endfunction

    function longint clip(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint clip_st(longint v);
      return clip(v, ST_W);
    endfunction

    // product with an unsigned coefficient, floored
    function longint scaled(longint v, longint coef, int sh);
      return (v * coef) >>> sh;
    endfunction

    function longint run_bands(int ch, longint x);
      longint bo, mi, mo, ho;
      bass_mem[ch] = clip_st(bass_mem[ch] + scaled(clip_st(x - bass_mem[ch]), bass_pole, 15));
      bo = clip_st(x + scaled(clip_st(bass_mem[ch] - x), bass_blend, 14));
      mi = clip_st(x - bass_mem[ch]);
      mo = clip_st(scaled(mi, mid_feed, 14) + mid_mem[ch]);
      mid_mem[ch] = clip_st(mi - scaled(mo, mid_back, 15));
      treble_mem[ch] = clip_st(treble_mem[ch] +
                               scaled(clip_st(mi - treble_mem[ch]), treble_pole, 15));
      ho = clip_st(mi + scaled(clip_st(treble_mem[ch] - mi), treble_blend, 14));
      if (solo) return mo;
      return clip_st(bo + mo + ho);
    endfunction

    function void take_pair(smp_t l, smp_t r, logic lst);
      longint wl, wr, m, sd, ol, orr;
      pair_t p;
      wl = run_bands(0, longint'(l) * (longint'(1) <<< FRAC));
      wr = run_bands(1, longint'(r) * (longint'(1) <<< FRAC));
      m = clip_st((wl + wr) >>> 1);
      sd = clip_st((wl - wr) >>> 1);
      sd = clip_st(scaled(sd, side_scale, 14));
      ol = clip(scaled(clip_st(m + sd), out_gain, 12 + FRAC), SAMPLE_W);
      orr = clip(scaled(clip_st(m - sd), out_gain, 12 + FRAC), SAMPLE_W);
      p.left = ol[SAMPLE_W-1:0];
      p.right = orr[SAMPLE_W-1:0];
      p.last = lst;
      due_pairs.push_back(p);
    endfunction

    function void match_pair(pair_t got);
      pair_t want;
      if (due_pairs.size() == 0) begin
        $display("%0t: unexpected word L=%0d R=%0d end=%0b", $time,
                 got.left, got.right, got.last);
        errors++;
        return;
      end
      want = due_pairs.pop_front();
      if (got.left !== want.left) begin
        $display("%0t: left_out expected %0d actual %0d", $time, want.left, got.left);
        errors++;
      end
      if (got.right !== want.right) begin
        $display("%0t: right_out expected %0d actual %0d", $time, want.right, got.right);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: block_end expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return due_pairs.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 20;   // merge stage plus lanes, with margin

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  sswe_in_if  in_ch();
  sswe_out_if out_ch();

  stereo_shelf_eq_width_enhancer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stereo_eq_ledger sb;
  bit  steady;      // when set, neither side idles
  int  stall_left;
  int  rdy_gap;
  int  cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pause_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample draw: extremes, full-scale noise, and quieter signals of varying level.
  function automatic smp_t draw_sample();
    int   r;
    smp_t s;
    r = $urandom_range(0, 15);
    s = SAMPLE_W'($urandom);
    case (r)
      0: s = {1'b0, {(SAMPLE_W-1){1'b1}}};
      1: s = {1'b1, {(SAMPLE_W-1){1'b0}}};
      2: s = '0;
      3: s = '1;
      4, 5, 6, 7: ;
      default: s = s >>> $urandom_range(1, 18);
    endcase
    return s;
  endfunction

  // Register draw: mostly inside the nominal range, sometimes zero or any bit pattern.
  function automatic logic [CFG_W-1:0] draw_reg(logic [IDX_W-1:0] idx);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CFG_W'($urandom);
    case (idx)
      REG_MID_FEED:     return CFG_W'($urandom_range(0, 65535));
      REG_BASS_BLEND,
      REG_TREBLE_BLEND: return CFG_W'($urandom_range(0, 49152));
      REG_OUT_GAIN:     return CFG_W'($urandom_range(0, 16383));
      REG_WIDTH_SOLO:
        return {1'($urandom_range(0, 3) == 0), 16'($urandom_range(16384, 24576))};
      default:          return CFG_W'($urandom_range(0, 32768));
    endcase
  endfunction

  // Sink side: hold ready low for random stretches.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rdy_gap = pause_len();
      if (rdy_gap == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left <= rdy_gap - 1;
      end
    end
  end

  // Check every word the block hands over.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.match_pair('{out_ch.left_out, out_ch.right_out, out_ch.block_end});
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one word and hold it until taken; then maybe drop valid for a while.
  task automatic send_pair(input smp_t l, input smp_t r, input logic lst);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.left_in <= l;
    in_ch.right_in <= r;
    in_ch.block_last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_pair(l, r, lst);
    gap = pause_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected word is back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write all eight registers back to back; the block must be idle.
  task automatic load_regs(input reg_plan_t plan);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data <= plan[i];
      sb.set_reg(IDX_W'(i), plan[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random stream: mostly independent channels, some mono and some anti-phase pairs.
  task automatic random_run(input int count, input bit mid_hold);
    smp_t l, r;
    int   kind;
    for (int i = 0; i < count; i++) begin
      l = draw_sample();
      kind = $urandom_range(0, 5);
      case (kind)
        0: r = l;
        1: r = -l;
        default: r = draw_sample();
      endcase
      send_pair(l, r, $urandom_range(0, 7) == 0);
      if (mid_hold && i == count / 2) drain();
    end
  endtask

  localparam smp_t S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam smp_t S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  initial begin
    reg_plan_t plan;
    sb = new();
    cycles <= 0;
    steady <= 1'b1;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.left_in <= '0;
    in_ch.right_in <= '0;
    in_ch.block_last <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: all filters off, unity gain and width.
    send_pair('0, '0, 1'b0);
    send_pair(S_MAX, S_MAX, 1'b0);
    send_pair(S_MIN, S_MIN, 1'b1);
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(S_MIN, S_MAX, 1'b1);
    send_pair('1, 24'sd1, 1'b0);
    send_pair(24'sd123456, -24'sd654321, 1'b1);
    drain();

    // Every register at all ones, at or above its nominal range, solo on: drives saturation.
    foreach (plan[i]) plan[i] = '1;
    load_regs(plan);
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(S_MAX, S_MAX, 1'b1);
    send_pair(S_MIN, S_MIN, 1'b0);
    send_pair('0, S_MAX, 1'b0);
    drain();

    // Same coefficients with solo off and widest side scale: overflow in the band sum.
    plan[REG_WIDTH_SOLO] = 17'h0FFFF;
    plan[REG_OUT_GAIN] = 17'd16383;
    load_regs(plan);
    send_pair(S_MAX, S_MIN, 1'b1);
    send_pair(S_MIN, S_MAX, 1'b0);
    send_pair(S_MAX, S_MAX, 1'b0);
    drain();

    // Everything zero: no gain, no width.
    foreach (plan[i]) plan[i] = '0;
    load_regs(plan);
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(24'sd4242, -24'sd77, 1'b1);
    drain();

    // Nominal maxima.
    plan[REG_BASS_POLE] = 17'd32768;
    plan[REG_TREBLE_POLE] = 17'd32768;
    plan[REG_MID_FEED] = 17'd65535;
    plan[REG_MID_BACK] = 17'd32768;
    plan[REG_BASS_BLEND] = 17'd49152;
    plan[REG_TREBLE_BLEND] = 17'd49152;
    plan[REG_OUT_GAIN] = 17'd16383;
    plan[REG_WIDTH_SOLO] = 17'd24576;
    load_regs(plan);
    send_pair(S_MAX, '0, 1'b0);
    send_pair('0, S_MIN, 1'b0);
    send_pair(S_MIN, S_MAX, 1'b1);
    drain();

    // Random phases, each with its own register set; some run without any idling.
    for (int ph = 0; ph < 12; ph++) begin
      foreach (plan[i]) plan[i] = draw_reg(IDX_W'(i));
      load_regs(plan);
      steady <= (ph % 3 == 0);
      random_run(160, ph % 4 == 1);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
